// ----- rtl/clt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and constants of the command-line tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

  // Upper bound on the per-token body length, applied after the register.
  localparam int unsigned TOKEN_LEN_LIMIT = 255;

  // Result queue between the lexer and the output stage.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Token type codes carried on a token end.
  localparam logic [3:0] TOK_STRING  = 4'd0;
  localparam logic [3:0] TOK_NEWLINE = 4'd1;
  localparam logic [3:0] TOK_END     = 4'd2;
  localparam logic [3:0] TOK_SEMI    = 4'd3;
  localparam logic [3:0] TOK_AMP     = 4'd4;
  localparam logic [3:0] TOK_LESS    = 4'd5;
  localparam logic [3:0] TOK_GREATER = 4'd6;
  localparam logic [3:0] TOK_CARET   = 4'd7;
  localparam logic [3:0] TOK_GROUP   = 4'd8;
  localparam logic [3:0] TOK_RPAREN  = 4'd9;
  localparam logic [3:0] TOK_PIPE    = 4'd10;

  typedef struct packed {
    logic       token_end;
    logic [7:0] body_char;
    logic [3:0] token_type;
  } result_t;

  // Up to two results produced by one accepted character.
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage
`default_nettype wire

// ----- rtl/clt_lexer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// clt_lexer
// Front end: holds the lexer state and the length register, classifies each
// accepted character and produces zero to two results for the queue.
// ----------------------------------------------------------------------------
module clt_lexer (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic [7:0]     cfg_wdata,
  input  wire logic           accept,
  input  wire logic [7:0]     char_in,
  input  wire logic           end_of_input,
  output clt_pkg::push_t      push
);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_STRING = 2'd1,
    MODE_GROUP  = 2'd2
  } mode_t;

  localparam logic [1:0] Q_NONE   = 2'd0;
  localparam logic [1:0] Q_SINGLE = 2'd1;
  localparam logic [1:0] Q_DOUBLE = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_LESS  = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_CARET = 8'h5e;
  localparam logic [7:0] CH_PIPE  = 8'h7c;

  logic [7:0] max_token_len;
  mode_t      mode, mode_next;
  logic [1:0] quote, quote_next;
  logic [7:0] depth, depth_next;
  logic [7:0] count, count_next;

  logic [7:0] eff_limit;
  logic       full;
  logic [1:0] qc;
  logic       delim;
  logic       idle_pass;

  clt_pkg::result_t body_res;
  clt_pkg::result_t idle_res;
  logic             idle_has;

  function automatic clt_pkg::result_t end_of(input logic [3:0] t);
    clt_pkg::result_t r;
    r.token_end  = 1'b1;
    r.body_char  = 8'd0;
    r.token_type = t;
    return r;
  endfunction

  always_comb begin
    if (max_token_len == 8'd0) begin
      eff_limit = 8'd1;
    end else if ({8'd0, max_token_len} > 16'(clt_pkg::TOKEN_LEN_LIMIT)) begin
      eff_limit = 8'(clt_pkg::TOKEN_LEN_LIMIT);
    end else begin
      eff_limit = max_token_len;
    end
  end

  assign full  = (count >= eff_limit);
  assign qc    = (char_in == CH_SQ) ? Q_SINGLE : (char_in == CH_DQ) ? Q_DOUBLE : Q_NONE;
  assign delim = char_in inside {CH_SPACE, CH_TAB, CH_NL, CH_SEMI, CH_AMP, CH_LESS, CH_GT,
                                 CH_CARET, CH_LPAR, CH_RPAR, CH_PIPE};

  assign body_res.token_end  = 1'b0;
  assign body_res.body_char  = char_in;
  assign body_res.token_type = clt_pkg::TOK_STRING;

  always_comb begin
    mode_next  = mode;
    quote_next = quote;
    depth_next = depth;
    count_next = count;
    push       = '0;
    idle_pass  = 1'b0;
    idle_res   = '0;
    idle_has   = 1'b0;

    case (mode)
      MODE_STRING: begin
        if (end_of_input || full) begin
          push.count = 2'd1;
          push.res0  = end_of(clt_pkg::TOK_STRING);
          idle_pass  = 1'b1;
        end else if (quote != Q_NONE) begin
          if (qc == quote) begin
            quote_next = Q_NONE;
          end else begin
            push.count = 2'd1;
            push.res0  = body_res;
            count_next = count + 8'd1;
          end
        end else if (delim) begin
          push.count = 2'd1;
          push.res0  = end_of(clt_pkg::TOK_STRING);
          idle_pass  = 1'b1;
        end else if (qc != Q_NONE) begin
          quote_next = qc;
        end else begin
          push.count = 2'd1;
          push.res0  = body_res;
          count_next = count + 8'd1;
        end
      end
      MODE_GROUP: begin
        if (end_of_input) begin
          push.count = 2'd1;
          push.res0  = end_of(clt_pkg::TOK_GROUP);
          idle_pass  = 1'b1;
        end else if (full || (quote == Q_NONE && char_in == CH_RPAR && depth <= 8'd1)) begin
          // Close the group; an overflowing character is dropped.
          push.count = 2'd1;
          push.res0  = end_of(clt_pkg::TOK_GROUP);
          mode_next  = MODE_IDLE;
          quote_next = Q_NONE;
          depth_next = 8'd0;
          count_next = 8'd0;
        end else begin
          push.count = 2'd1;
          push.res0  = body_res;
          count_next = count + 8'd1;
          if (quote != Q_NONE) begin
            if (qc == quote) quote_next = Q_NONE;
          end else if (char_in == CH_LPAR) begin
            if (depth != 8'd255) depth_next = depth + 8'd1;
          end else if (char_in == CH_RPAR) begin
            depth_next = depth - 8'd1;
          end else if (qc != Q_NONE) begin
            quote_next = qc;
          end
        end
      end
      default: begin
        idle_pass = 1'b1;
      end
    endcase

    // Idle handling, also for a delimiter handed back by a closed string.
    if (idle_pass) begin
      mode_next  = MODE_IDLE;
      quote_next = Q_NONE;
      depth_next = 8'd0;
      count_next = 8'd0;
      if (end_of_input) begin
        idle_has = 1'b1;
        idle_res = end_of(clt_pkg::TOK_END);
      end else begin
        case (char_in)
          CH_SPACE, CH_TAB, CH_NUL: idle_has = 1'b0;
          CH_NL:    begin idle_has = 1'b1; idle_res = end_of(clt_pkg::TOK_NEWLINE); end
          CH_SEMI:  begin idle_has = 1'b1; idle_res = end_of(clt_pkg::TOK_SEMI);    end
          CH_AMP:   begin idle_has = 1'b1; idle_res = end_of(clt_pkg::TOK_AMP);     end
          CH_LESS:  begin idle_has = 1'b1; idle_res = end_of(clt_pkg::TOK_LESS);    end
          CH_GT:    begin idle_has = 1'b1; idle_res = end_of(clt_pkg::TOK_GREATER); end
          CH_CARET: begin idle_has = 1'b1; idle_res = end_of(clt_pkg::TOK_CARET);   end
          CH_RPAR:  begin idle_has = 1'b1; idle_res = end_of(clt_pkg::TOK_RPAREN);  end
          CH_PIPE:  begin idle_has = 1'b1; idle_res = end_of(clt_pkg::TOK_PIPE);    end
          CH_LPAR: begin
            mode_next  = MODE_GROUP;
            depth_next = 8'd1;
          end
          default: begin
            mode_next = MODE_STRING;
            if (qc != Q_NONE) begin
              quote_next = qc;
            end else begin
              idle_has   = 1'b1;
              idle_res   = body_res;
              count_next = 8'd1;
            end
          end
        endcase
      end
      if (idle_has) begin
        if (push.count == 2'd0) begin
          push.res0 = idle_res;
        end else begin
          push.res1 = idle_res;
        end
        push.count = push.count + 2'd1;
      end
    end

    if (!accept) push.count = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_token_len <= 8'd255;
      mode          <= MODE_IDLE;
      quote         <= Q_NONE;
      depth         <= 8'd0;
      count         <= 8'd0;
    end else begin
      if (cfg_we) max_token_len <= cfg_wdata;
      if (accept) begin
        mode  <= mode_next;
        quote <= quote_next;
        depth <= depth_next;
        count <= count_next;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/clt_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// clt_queue
// Short result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module clt_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire clt_pkg::push_t    push,
  input  wire logic              pop,
  output clt_pkg::result_t       head,
  output logic                   head_valid,
  output logic                   room_for_two
);

  clt_pkg::result_t entries [clt_pkg::QUEUE_DEPTH];

  logic [clt_pkg::QPTR_W-1:0] wptr, rptr;
  logic [clt_pkg::QCNT_W-1:0] fill, fill_next;
  logic                       do_pop;

  assign head         = entries[rptr];
  assign head_valid   = (fill != '0);
  assign do_pop       = pop && head_valid;
  assign room_for_two = (fill <= clt_pkg::QCNT_W'(clt_pkg::QUEUE_DEPTH - 2));
  assign fill_next    = fill + clt_pkg::QCNT_W'(push.count) - clt_pkg::QCNT_W'(do_pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[wptr] <= push.res0;
    if (push.count == 2'd2) entries[wptr + clt_pkg::QPTR_W'(1)] <= push.res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      wptr <= wptr + clt_pkg::QPTR_W'(push.count);
      if (do_pop) rptr <= rptr + clt_pkg::QPTR_W'(1);
      fill <= fill_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/clt_emit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// clt_emit
// Back end: output register that drains the result queue.
// ----------------------------------------------------------------------------
module clt_emit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire clt_pkg::result_t  head,
  input  wire logic              head_valid,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output clt_pkg::result_t       out_res
);

  // Load when the register is empty or its request leaves this cycle.
  assign pop = head_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (pop) out_res <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/command_line_tokenizer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Splits a character stream into shell tokens: body characters, then a token
// end carrying the token type.
// ----------------------------------------------------------------------------
//
//   channel  | valid      | stall      | payload
//   ---------+------------+------------+----------------------------------
//   input    | in_valid   | in_stall   | char_in, end_of_input
//   output   | out_valid  | out_stall  | token_end, body_char, token_type
//   config   | cfg_we     | (none)     | cfg_wdata -> max_token_len
//
// One character is taken per cycle while in_stall is low; the lexer state
// updates in that cycle. Each character yields zero to two requests, which
// pass through a four-entry queue and an output register. The output
// delivers one request per cycle while out_stall is low, so a run of
// characters that each make two requests is paced by the output port.
// in_stall rises when the queue has fewer than two free entries.
// Synchronous reset returns the lexer to idle and max_token_len to 255.
// ----------------------------------------------------------------------------
module command_line_tokenizer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] char_in,
  input  wire logic       end_of_input,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            token_end,
  output logic [7:0]      body_char,
  output logic [3:0]      token_type
);

  clt_pkg::push_t   push;
  clt_pkg::result_t head;
  clt_pkg::result_t out_res;
  logic             head_valid;
  logic             room_for_two;
  logic             pop;
  logic             accept;

  // Hold input whenever one character could overfill the queue.
  assign in_stall = !room_for_two;
  assign accept   = in_valid && !in_stall;

  // Front: classify the character and advance the lexer state.
  clt_lexer u_lexer (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .accept       (accept),
    .char_in      (char_in),
    .end_of_input (end_of_input),
    .push         (push)
  );

  // Decouple the lexer from output back-pressure.
  clt_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .pop          (pop),
    .head         (head),
    .head_valid   (head_valid),
    .room_for_two (room_for_two)
  );

  // Back: drive the output request from a register.
  clt_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign token_end  = out_res.token_end;
  assign body_char  = out_res.body_char;
  assign token_type = out_res.token_type;

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for command_line_tokenizer. A shadow lexer in a small
// scoreboard class predicts every body character and token end for each
// accepted character request; a monitor compares each delivered result with
// the oldest prediction. Directed characters come first. Random phases with
// different token length limits, random idling on both channels, a long
// receiver hold-off and deep paren nesting follow.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int GAP_MAX         = 18;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 20;
  localparam int ITEMS_PER_PHASE = 40;
  localparam int NUM_PHASES      = 8;
  localparam int DEPTH_SAT       = 255;

  // Characters with a meaning to the lexer.
  localparam bit [7:0] CH_NUL     = 8'h00;
  localparam bit [7:0] CH_TAB     = "\t";
  localparam bit [7:0] CH_NEWLINE = "\n";
  localparam bit [7:0] CH_SPACE   = " ";
  localparam bit [7:0] CH_SEMI    = ";";
  localparam bit [7:0] CH_AMP     = "&";
  localparam bit [7:0] CH_LESS    = "<";
  localparam bit [7:0] CH_GREATER = ">";
  localparam bit [7:0] CH_CARET   = "^";
  localparam bit [7:0] CH_PIPE    = "|";
  localparam bit [7:0] CH_LPAREN  = "(";
  localparam bit [7:0] CH_RPAREN  = ")";
  localparam bit [7:0] CH_SQUOTE  = "'";
  localparam bit [7:0] CH_DQUOTE  = "\"";

  typedef enum logic [1:0] {LX_IDLE, LX_STRING, LX_GROUP} lex_mode_t;
  typedef enum logic [1:0] {QT_NONE, QT_SINGLE, QT_DOUBLE} quote_t;

  // --------------------------------------------------------------------------
  // Shadow lexer plus the queue of predicted results.
  // --------------------------------------------------------------------------
  class token_tracker_t;
    lex_mode_t        mode;
    quote_t           quote;
    bit [7:0]         depth;
    bit [7:0]         body_len;
    bit [7:0]         max_len;
    clt_pkg::result_t expected_tokens[$];
    int               mismatches;

    function new();
      max_len    = 8'd255;
      mismatches = 0;
      go_idle();
    endfunction

    static function quote_t quote_of(bit [7:0] c);
      if (c == CH_SQUOTE) return QT_SINGLE;
      if (c == CH_DQUOTE) return QT_DOUBLE;
      return QT_NONE;
    endfunction

    static function bit is_delim(bit [7:0] c);
      return c inside {CH_SPACE, CH_TAB, CH_NEWLINE, CH_SEMI, CH_AMP, CH_LESS,
                       CH_GREATER, CH_CARET, CH_LPAREN, CH_RPAREN, CH_PIPE};
    endfunction

    function void go_idle();
      mode     = LX_IDLE;
      quote    = QT_NONE;
      depth    = '0;
      body_len = '0;
    endfunction

    function int token_limit();
      int l;
      l = max_len;
      if (l == 0) l = 1;
      if (l > clt_pkg::TOKEN_LEN_LIMIT) l = clt_pkg::TOKEN_LEN_LIMIT;
      return l;
    endfunction

    function void push_body(bit [7:0] c);
      body_len++;
      expected_tokens.push_back(clt_pkg::result_t'{1'b0, c, 4'd0});
    endfunction

    function void push_end(logic [3:0] kind);
      expected_tokens.push_back(clt_pkg::result_t'{1'b1, 8'h00, kind});
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction

    // Start of a token, or a character handed back by a closed string.
    function void idle_char(bit [7:0] c, bit eoi);
      if (eoi) begin
        push_end(clt_pkg::TOK_END);
        return;
      end
      case (c)
        CH_SPACE, CH_TAB, CH_NUL: ;
        CH_NEWLINE: push_end(clt_pkg::TOK_NEWLINE);
        CH_SEMI:    push_end(clt_pkg::TOK_SEMI);
        CH_AMP:     push_end(clt_pkg::TOK_AMP);
        CH_LESS:    push_end(clt_pkg::TOK_LESS);
        CH_GREATER: push_end(clt_pkg::TOK_GREATER);
        CH_CARET:   push_end(clt_pkg::TOK_CARET);
        CH_RPAREN:  push_end(clt_pkg::TOK_RPAREN);
        CH_PIPE:    push_end(clt_pkg::TOK_PIPE);
        CH_LPAREN: begin
          mode  = LX_GROUP;
          depth = 8'd1;
        end
        default: begin
          mode = LX_STRING;
          if (quote_of(c) != QT_NONE) quote = quote_of(c);
          else push_body(c);
        end
      endcase
    endfunction

    // Note one accepted character request and predict its results.
    function void note_char(bit [7:0] c, bit eoi);
      bit rescan;
      rescan = 1'b0;
      case (mode)
        LX_STRING: begin
          if (eoi || body_len >= token_limit()) begin
            push_end(clt_pkg::TOK_STRING);
            go_idle();
            rescan = 1'b1;
          end else if (quote != QT_NONE) begin
            if (quote_of(c) == quote) quote = QT_NONE;
            else push_body(c);
          end else if (is_delim(c)) begin
            push_end(clt_pkg::TOK_STRING);
            go_idle();
            rescan = 1'b1;
          end else if (quote_of(c) != QT_NONE) begin
            quote = quote_of(c);
          end else begin
            push_body(c);
          end
        end
        LX_GROUP: begin
          if (eoi) begin
            push_end(clt_pkg::TOK_GROUP);
            go_idle();
            rescan = 1'b1;
          end else if (body_len >= token_limit()) begin
            // full group: close it and drop the character
            go_idle();
            push_end(clt_pkg::TOK_GROUP);
          end else if (quote != QT_NONE) begin
            if (quote_of(c) == quote) quote = QT_NONE;
            push_body(c);
          end else if (c == CH_LPAREN) begin
            if (depth < DEPTH_SAT) depth++;
            push_body(c);
          end else if (c == CH_RPAREN) begin
            if (depth <= 1) begin
              go_idle();
              push_end(clt_pkg::TOK_GROUP);
            end else begin
              depth--;
              push_body(c);
            end
          end else begin
            if (quote_of(c) != QT_NONE) quote = quote_of(c);
            push_body(c);
          end
        end
        default: begin
          go_idle();
          rescan = 1'b1;
        end
      endcase
      if (rescan) idle_char(c, eoi);
    endfunction

    // Compare one delivered result with the oldest prediction.
    function void check_token(logic te, logic [7:0] bc, logic [3:0] tt);
      clt_pkg::result_t want;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result end=%0b char=%02h type=%0d",
                 $time, te, bc, tt);
        return;
      end
      want = expected_tokens.pop_front();
      if (te !== want.token_end) begin
        mismatches++;
        $display("%0t: token_end expected %0b actual %0b", $time, want.token_end, te);
      end
      if (bc !== want.body_char) begin
        mismatches++;
        $display("%0t: body_char expected %02h actual %02h", $time, want.body_char, bc);
      end
      if (tt !== want.token_type) begin
        mismatches++;
        $display("%0t: token_type expected %0d actual %0d", $time, want.token_type, tt);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] char_in;
  logic       end_of_input;
  logic       out_valid;
  logic       out_stall;
  logic       token_end;
  logic [7:0] body_char;
  logic [3:0] token_type;

  command_line_tokenizer uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_in      (char_in),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_end    (token_end),
    .body_char    (body_char),
    .token_type   (token_type)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  token_tracker_t tracker;
  int tx_gap_max;      // longest gap the sender draws before a request
  int rx_gap_max;      // longest stall the receiver draws after a result
  bit hold_off_req;    // ask the receiver for one long hold-off
  int sent_items;      // requests in the current phase that are not space, tab or NUL
  int cycle_count = 0;

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Check every result taken from the output channel.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall)
      tracker.check_token(token_end, body_char, token_type);
  end

  // Receiver: stall a random count after each taken result; on request, hold
  // off for a long stretch so the block backs up and stalls its input.
  initial begin : result_sink
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        n = HOLD_OFF_CYCLES;
      end else if (!rst && out_valid === 1'b1 && !out_stall) begin
        n = (rx_gap_max == 0) ? 0 : $urandom_range(0, rx_gap_max);
      end else begin
        n = 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Character sources
  // --------------------------------------------------------------------------
  // Any byte that neither ends nor quotes a plain string.
  function automatic bit [7:0] word_char();
    bit [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (token_tracker_t::is_delim(c) || token_tracker_t::quote_of(c) != QT_NONE);
    return c;
  endfunction

  // Any byte but the given quote.
  function automatic bit [7:0] byte_except(bit [7:0] q);
    bit [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == q);
    return c;
  endfunction

  // Group filler: anything but parens and quotes.
  function automatic bit [7:0] group_char();
    bit [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c inside {CH_LPAREN, CH_RPAREN, CH_SQUOTE, CH_DQUOTE});
    return c;
  endfunction

  function automatic bit [7:0] op_char();
    case ($urandom_range(0, 6))
      0:       return CH_SEMI;
      1:       return CH_AMP;
      2:       return CH_LESS;
      3:       return CH_GREATER;
      4:       return CH_CARET;
      5:       return CH_RPAREN;
      default: return CH_PIPE;
    endcase
  endfunction

  function automatic bit [7:0] blank_char();
    case ($urandom_range(0, 2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_NUL;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------
  // Offer one character request after a random gap and hold it until taken.
  task automatic send_item(input bit [7:0] c, input bit eoi);
    int gap;
    gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    char_in      <= c;
    end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_char(c, eoi);
    if (eoi || !(c inside {CH_SPACE, CH_TAB, CH_NUL})) sent_items++;
  endtask

  task automatic send_eoi();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Quoted run: open, content with any byte but the quote, and a close if close_it is set.
  task automatic send_quoted(input bit close_it);
    bit [7:0] q;
    int n;
    q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
    n = $urandom_range(0, 6);
    send_item(q, 1'b0);
    repeat (n) send_item(byte_except(q), 1'b0);
    if (close_it) send_item(q, 1'b0);
  endtask

  // Plain string with optional quoted runs and a random terminator.
  task automatic send_word();
    int len;
    len = $urandom_range(1, 10);
    repeat (len) begin
      if ($urandom_range(0, 7) == 0) send_quoted(1'b1);
      else send_item(word_char(), 1'b0);
    end
    case ($urandom_range(0, 6))
      0, 1: send_item(CH_SPACE, 1'b0);
      2:    send_item(CH_TAB, 1'b0);
      3:    send_item(CH_NEWLINE, 1'b0);
      4:    send_item(op_char(), 1'b0);
      5:    send_item(CH_LPAREN, 1'b0);
      default: ;
    endcase
  endtask

  // Paren group with nesting, quotes and filler; close it unless broken.
  task automatic send_group(input bit close_it);
    int steps;
    int level;
    level = 1;
    steps = $urandom_range(0, 12);
    send_item(CH_LPAREN, 1'b0);
    repeat (steps) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          send_item(CH_LPAREN, 1'b0);
          level++;
        end
        2, 3: begin
          if (level > 1) begin
            send_item(CH_RPAREN, 1'b0);
            level--;
          end
        end
        4:       send_quoted(1'b1);
        default: send_item(group_char(), 1'b0);
      endcase
    end
    if (close_it) repeat (level) send_item(CH_RPAREN, 1'b0);
  endtask

  // One random fragment: mostly well-formed tokens, some noise and breakage.
  task automatic send_fragment();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      send_word();
    end else if (kind < 55) begin
      send_group(1'b1);
    end else if (kind < 67) begin
      send_item(op_char(), 1'b0);
    end else if (kind < 76) begin
      n = $urandom_range(1, 3);
      repeat (n) send_item(blank_char(), 1'b0);
    end else if (kind < 81) begin
      send_item(CH_NEWLINE, 1'b0);
    end else if (kind < 84) begin
      send_eoi();
    end else if (kind < 92) begin
      n = $urandom_range(1, 4);
      repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      // broken: unclosed quote or group, then newline or end of input
      if ($urandom_range(0, 1)) begin
        send_item(word_char(), 1'b0);
        send_quoted(1'b0);
      end else begin
        send_group(1'b0);
      end
      if ($urandom_range(0, 1)) send_eoi();
      else send_item(CH_NEWLINE, 1'b0);
    end
  endtask

  // Drop valid and wait until every predicted result has been taken.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_token_limit(input bit [7:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tracker.max_len = value;
  endtask

  function automatic bit [7:0] phase_limit(int p);
    case (p)
      0, 7:    return 8'd255;
      1:       return 8'd1;
      2:       return 8'd0;
      3:       return 8'd3;
      4:       return 8'd12;
      6:       return 8'd2;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int phase;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    char_in      = '0;
    end_of_input = 1'b0;
    hold_off_req = 1'b0;
    sent_items   = 0;
    tx_gap_max   = GAP_MAX;
    rx_gap_max   = GAP_MAX;
    tracker      = new();

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every operator, the blanks, newline, a quoted string that a
    // paren ends, a group with nesting and a quoted paren, end of input
    // inside a string and in idle.
    send_item(CH_SEMI, 1'b0);    send_item(CH_AMP, 1'b0);
    send_item(CH_LESS, 1'b0);    send_item(CH_GREATER, 1'b0);
    send_item(CH_CARET, 1'b0);   send_item(CH_RPAREN, 1'b0);
    send_item(CH_PIPE, 1'b0);    send_item(CH_SPACE, 1'b0);
    send_item(CH_TAB, 1'b0);     send_item(CH_NUL, 1'b0);
    send_item(CH_NEWLINE, 1'b0); send_item(8'hff, 1'b0);
    send_item(CH_SQUOTE, 1'b0);  send_item(CH_SPACE, 1'b0);
    send_item(CH_SQUOTE, 1'b0);  send_item(CH_LPAREN, 1'b0);
    send_item(CH_LPAREN, 1'b0);  send_item(CH_DQUOTE, 1'b0);
    send_item(CH_RPAREN, 1'b0);  send_item(CH_DQUOTE, 1'b0);
    send_item(CH_RPAREN, 1'b0);  send_item(CH_RPAREN, 1'b0);
    send_item(8'h80, 1'b0);      send_eoi();
    send_eoi();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      set_token_limit(phase_limit(phase));
      tx_gap_max = (phase % 4 == 1 || phase == 2) ? 0 : GAP_MAX;
      rx_gap_max = (phase % 4 == 3) ? 0 : GAP_MAX;
      // Back up the block: long receiver hold-off while requests keep coming.
      if (phase == 2) hold_off_req = 1'b1;
      if (phase == 0) begin
        // Deep nesting saturates the depth and fills the group, then the
        // extra paren is dropped; a long word overflows and restarts.
        send_item(CH_LPAREN, 1'b0);
        repeat (DEPTH_SAT + 1) send_item(CH_LPAREN, 1'b0);
        send_item(CH_RPAREN, 1'b0);
        repeat (DEPTH_SAT + 3) send_item(word_char(), 1'b0);
        send_item(CH_SPACE, 1'b0);
      end
      sent_items = 0;
      while (sent_items < ITEMS_PER_PHASE) send_fragment();
      send_eoi();
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
